// ===== rtl/core/drbm_pkg.sv =====
// Shared types and constants for the dirty-rectangle bounding-box merge core.
package drbm_pkg;

    localparam int COORD_BITS = 16;
    localparam int TDATA_W    = 4 * COORD_BITS;
    localparam int TUSER_W    = 2;
    localparam int CFG_W      = 16;

    // Configuration register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] DISP_W_RST = CFG_W'(320);
    localparam logic [CFG_W-1:0] DISP_H_RST = CFG_W'(240);

    typedef logic [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_ALL_ONES = '1;

    // One input beat, unpacked
    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        logic   copy_annotate;
        logic   last_rect;
        logic   empty_request;
    } rect_item_t;

    // One result beat, unpacked
    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        logic   covers_full_screen;
        logic   box_was_replaced;
    } box_result_t;

endpackage

// ===== rtl/core/dirty_rect_bounding_box_merge_core.sv =====
// Top level of the dirty-rectangle bounding-box merge core.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  rect beat: tdata coords, tlast, tuser flags
// m_*       out  m_tvalid/m_tready  merged box: tdata coords, tuser flags
// cfg_*     in   cfg_wr_en          display width / height registers
//
// One rectangle per cycle while m_* is not stalled; the box of an emitting beat
// goes through the input register and then the result register to m_*.
// The rate is set by the single merge stage between the input and result
// registers: four compares, a bounds check and a span compare.
// aresetn (synchronous) clears both stages, the running box and the
// pair-position bit, and sets the display to 320 x 240.
// A stalled m_tready holds the result register; s_tready drops only when
// the input register is full as well.
module dirty_rect_bounding_box_merge_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Rectangle in
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [drbm_pkg::TDATA_W-1:0] s_tdata,  // rect_left, rect_top, rect_right, rect_bottom
    input  logic [drbm_pkg::TUSER_W-1:0] s_tuser,  // copy_annotate, empty_request
    input  logic                         s_tlast,  // last_rect
    // Merged box out
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [drbm_pkg::TDATA_W-1:0] m_tdata,  // box_left, box_top, box_right, box_bottom
    output logic [drbm_pkg::TUSER_W-1:0] m_tuser,  // covers_full_screen, box_was_replaced
    // Configuration writes
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [drbm_pkg::CFG_W-1:0]   cfg_wdata
);
    import drbm_pkg::*;

    logic [CFG_W-1:0] disp_w_reg, disp_h_reg;

    rect_item_t  s_item;
    rect_item_t  item;
    logic        item_vld;
    logic        advance;
    logic        res_vld;
    box_result_t result;

    // Display size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_w_reg <= DISP_W_RST;
            disp_h_reg <= DISP_H_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_WIDTH:  disp_w_reg <= cfg_wdata;
                CFG_IDX_HEIGHT: disp_h_reg <= cfg_wdata;
            endcase
        end
    end

    // Unpack the input beat
    always_comb begin
        s_item.left          = s_tdata[COORD_BITS-1:0];
        s_item.top           = s_tdata[2*COORD_BITS-1:COORD_BITS];
        s_item.right         = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        s_item.bottom        = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        s_item.copy_annotate = s_tuser[0];
        s_item.empty_request = s_tuser[1];
        s_item.last_rect     = s_tlast;
    end

    drbm_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    // Merge stage advances whenever the result slot can take a beat, so
    // every beat (emitting or not) waits for a free result slot
    drbm_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_vld (item_vld),
        .item     (item),
        .advance  (advance),
        .disp_w   (disp_w_reg),
        .disp_h   (disp_h_reg),
        .res_vld  (res_vld),
        .result   (result)
    );

    drbm_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_vld  (res_vld),
        .load_res  (result),
        .slot_free (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // A replaced box is the full screen, which always covers
    a_replaced_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("replaced box not flagged as full screen");

    // A kept box is non-empty and lies inside the display; this checks its right and bottom edges
    a_box_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |->
            (m_tdata[3*COORD_BITS-1:2*COORD_BITS] <= disp_w_reg) &&
            (m_tdata[4*COORD_BITS-1:3*COORD_BITS] <= disp_h_reg))
        else $error("merged box exceeds display");

    // Input backpressure only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_vld && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== rtl/core/drbm_in_reg.sv =====
// Input register stage: captures one rectangle beat per cycle while s_tready is high.
module drbm_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  drbm_pkg::rect_item_t s_item,
    input  logic                advance,
    output logic                item_vld,
    output drbm_pkg::rect_item_t item
);
    import drbm_pkg::*;

    logic       vld_reg;
    rect_item_t item_reg;

    // Stage empties or hands its beat on in the same cycle
    assign s_tready = !vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// ===== rtl/core/drbm_merge.sv =====
// Running bounding-box accumulator and final box check.
module drbm_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_vld,
    input  drbm_pkg::rect_item_t  item,
    input  logic                  advance,
    input  drbm_pkg::coord_t      disp_w,
    input  drbm_pkg::coord_t      disp_h,
    output logic                  res_vld,
    output drbm_pkg::box_result_t result
);
    import drbm_pkg::*;

    coord_t min_left_reg, min_top_reg, max_right_reg, max_bottom_reg;
    coord_t min_left_next, min_top_next, max_right_next, max_bottom_next;
    logic   odd_reg, odd_next;

    coord_t nl, nt, nr, nb;
    logic   take, bad_box, emit;

    always_comb begin
        take = !item.copy_annotate || odd_reg;
        nl   = (take && item.left   < min_left_reg)   ? item.left   : min_left_reg;
        nt   = (take && item.top    < min_top_reg)    ? item.top    : min_top_reg;
        nr   = (take && item.right  > max_right_reg)  ? item.right  : max_right_reg;
        nb   = (take && item.bottom > max_bottom_reg) ? item.bottom : max_bottom_reg;

        bad_box = (nr > disp_w) || (nb > disp_h) || (nl >= nr) || (nt >= nb);
        emit    = item.empty_request || item.last_rect;

        // Full screen always covers; merged box covers when its span matches
        if (item.empty_request || bad_box) begin
            result.left               = '0;
            result.top                = '0;
            result.right              = disp_w;
            result.bottom             = disp_h;
            result.covers_full_screen = 1'b1;
            result.box_was_replaced   = !item.empty_request;
        end else begin
            result.left               = nl;
            result.top                = nt;
            result.right              = nr;
            result.bottom             = nb;
            result.covers_full_screen = (coord_t'(nr - nl) == disp_w) &&
                                        (coord_t'(nb - nt) == disp_h);
            result.box_was_replaced   = 1'b0;
        end

        res_vld = item_vld && emit;

        // Run state restarts after every emitted box
        if (emit) begin
            min_left_next   = COORD_ALL_ONES;
            min_top_next    = COORD_ALL_ONES;
            max_right_next  = '0;
            max_bottom_next = '0;
            odd_next        = 1'b0;
        end else begin
            min_left_next   = nl;
            min_top_next    = nt;
            max_right_next  = nr;
            max_bottom_next = nb;
            odd_next        = !odd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_left_reg   <= COORD_ALL_ONES;
            min_top_reg    <= COORD_ALL_ONES;
            max_right_reg  <= '0;
            max_bottom_reg <= '0;
            odd_reg        <= 1'b0;
        end else if (item_vld && advance) begin
            min_left_reg   <= min_left_next;
            min_top_reg    <= min_top_next;
            max_right_reg  <= max_right_next;
            max_bottom_reg <= max_bottom_next;
            odd_reg        <= odd_next;
        end
    end

endmodule

// ===== rtl/core/drbm_out_reg.sv =====
// Result register driving the master-side stream.
module drbm_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load_vld,
    input  drbm_pkg::box_result_t        load_res,
    output logic                         slot_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [drbm_pkg::TDATA_W-1:0] m_tdata,
    output logic [drbm_pkg::TUSER_W-1:0] m_tuser
);
    import drbm_pkg::*;

    logic        vld_reg;
    box_result_t res_reg;

    assign slot_free = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (slot_free) begin
            vld_reg <= load_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && load_vld) begin
            res_reg <= load_res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {res_reg.bottom, res_reg.right, res_reg.top, res_reg.left};
    assign m_tuser  = {res_reg.box_was_replaced, res_reg.covers_full_screen};

endmodule
